### sv/rbbq_pkg.sv
// Shared constants, tables and types for the beam blockage quality block.
package rbbq_pkg;

  localparam int TAB_FRAC     = 20;
  localparam int CORDIC_STEPS = 24;
  localparam int ERF_X_W      = 19;
  localparam int ERF_Y_W      = 31;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 25;

  localparam logic [ERF_X_W-1:0] ERF_SAT = ERF_X_W'(6 << 16);
  localparam logic [ERF_Y_W-1:0] ONE_Q30 = ERF_Y_W'(1 << 30);

  localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADAR_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ELEV_ANGLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEV_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAUSS_IWIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ERF_NORM_INV = 3'd5;

  typedef struct packed {
    logic               start;
    logic [ERF_X_W-1:0] x;
  } erf_req_t;

  typedef struct packed {
    logic               done;
    logic [ERF_Y_W-1:0] y;
  } erf_rsp_t;

  // atan(2^-i) in degrees, Q20, rounded.
  function automatic logic [25:0] atan_q20(input logic [4:0] i);
    logic [25:0] v;
    case (i)
      5'd0:  v = 26'd47185920;
      5'd1:  v = 26'd27855475;
      5'd2:  v = 26'd14718068;
      5'd3:  v = 26'd7471121;
      5'd4:  v = 26'd3750058;
      5'd5:  v = 26'd1876857;
      5'd6:  v = 26'd938658;
      5'd7:  v = 26'd469357;
      5'd8:  v = 26'd234682;
      5'd9:  v = 26'd117342;
      5'd10: v = 26'd58671;
      5'd11: v = 26'd29335;
      5'd12: v = 26'd14668;
      5'd13: v = 26'd7334;
      5'd14: v = 26'd3667;
      5'd15: v = 26'd1833;
      5'd16: v = 26'd917;
      5'd17: v = 26'd458;
      5'd18: v = 26'd229;
      5'd19: v = 26'd115;
      5'd20: v = 26'd57;
      5'd21: v = 26'd29;
      5'd22: v = 26'd14;
      5'd23: v = 26'd7;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

  // Coefficients a1..a6 of the rational erf approximation, Q30.
  function automatic logic [26:0] erf_coef(input logic [2:0] k);
    logic [26:0] v;
    case (k)
      3'd0: v = 27'd75723579;
      3'd1: v = 27'd45399965;
      3'd2: v = 27'd9954153;
      3'd3: v = 27'd163224;
      3'd4: v = 27'd296962;
      3'd5: v = 27'd46239;
      default: v = 27'd0;
    endcase
    return v;
  endfunction

endpackage

### sv/rbbq_fifo.sv
// Short register queue carrying terrain angles from the front to the back.
module rbbq_fifo #(
  parameter int W     = 21,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### sv/rbbq_front.sv
// Front part: takes a bin, forms the arcsine argument and runs divide, root and CORDIC.
module rbbq_front #(
  parameter int AFB = 10,
  parameter int AW  = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic signed [14:0] terrain_height,
  input  logic [19:0]        ground_range,
  input  logic               ray_start,
  output logic               full,
  input  logic [24:0]        earth_radius_eff,
  input  logic signed [14:0] radar_height,
  output logic               q_push,
  output logic [AW:0]        q_data,
  input  logic               q_full
);

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_AA    = 4'd1;
  localparam logic [3:0] F_DD    = 4'd2;
  localparam logic [3:0] F_BB    = 4'd3;
  localparam logic [3:0] F_DB    = 4'd4;
  localparam logic [3:0] F_CHK   = 4'd5;
  localparam logic [3:0] F_DIV   = 4'd6;
  localparam logic [3:0] F_SQ    = 4'd7;
  localparam logic [3:0] F_ROOT  = 4'd8;
  localparam logic [3:0] F_CINIT = 4'd9;
  localparam logic [3:0] F_CORD  = 4'd10;
  localparam logic [3:0] F_FIN   = 4'd11;
  localparam logic [3:0] F_PUSH  = 4'd12;

  localparam int RND_SH = rbbq_pkg::TAB_FRAC - AFB;
  localparam logic signed [AW-1:0] FULL_ANG = AW'(90 << AFB);
  localparam logic signed [31:0]   Z_MAX    = 32'(90 << rbbq_pkg::TAB_FRAC);
  localparam logic signed [31:0]   Z_HALF   = 32'(1 << (RND_SH - 1));

  logic [3:0]            st_r;
  logic signed [26:0]    a_r, b_r;
  logic [19:0]           d_r;
  logic                  rs_r;
  logic signed [55:0]    num_r, den_r;
  logic                  neg_r;
  logic [47:0]           rem_r;
  logic [29:0]           s_r;
  logic [60:0]           n_r, r_r;
  logic [4:0]            cnt_r;
  logic signed [33:0]    x_r, y_r;
  logic signed [31:0]    z_r;
  logic signed [AW-1:0]  phi_r;

  logic signed [27:0]    mul_a, mul_b;
  logic signed [55:0]    prod;
  logic [55:0]           num_abs;
  logic                  mag_ge;
  logic [48:0]           rem_sh, rem_sub;
  logic                  div_ge;
  logic [59:0]           sq;
  logic [60:0]           rb, trial;
  logic                  root_ge;
  logic signed [33:0]    xsh, ysh;
  logic signed [31:0]    atan_s;
  logic signed [31:0]    zc, rnd;
  logic signed [AW-1:0]  phi_mag;

  // Shift towards zero, as a sign and magnitude shift.
  function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
                                                input logic [4:0] s);
    logic [33:0] m;
    m = v[33] ? 34'(-v) : 34'(v);
    m = m >> s;
    return v[33] ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    unique case (st_r)
      F_AA: begin
        mul_a = {a_r[26], a_r};
        mul_b = {a_r[26], a_r};
      end
      F_DD: begin
        mul_a = $signed({8'b0, d_r});
        mul_b = $signed({8'b0, d_r});
      end
      F_BB: begin
        mul_a = {b_r[26], b_r};
        mul_b = {b_r[26], b_r};
      end
      default: begin
        mul_a = $signed({8'b0, d_r});
        mul_b = {b_r[26], b_r};
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign num_abs = num_r[55] ? 56'(-num_r) : 56'(num_r);
  assign mag_ge  = num_abs >= $unsigned(den_r);

  assign rem_sh  = {rem_r, 1'b0};
  assign div_ge  = rem_sh >= {1'b0, den_r[47:0]};
  assign rem_sub = rem_sh - {1'b0, den_r[47:0]};

  assign sq      = s_r * s_r;
  assign rb      = 61'(1) << (6'd60 - {cnt_r, 1'b0});
  assign trial   = r_r + rb;
  assign root_ge = n_r >= trial;

  assign xsh     = shr_tz(x_r, cnt_r);
  assign ysh     = shr_tz(y_r, cnt_r);
  assign atan_s  = $signed({6'b0, rbbq_pkg::atan_q20(cnt_r)});

  always_comb begin
    if (z_r < 0) begin
      zc = '0;
    end else if (z_r > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = z_r;
    end
    rnd     = (zc + Z_HALF) >>> RND_SH;
    phi_mag = AW'(rnd);
  end

  assign full   = (st_r != F_IDLE);
  assign q_push = (st_r == F_PUSH) && !q_full;
  assign q_data = {rs_r, phi_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (push) begin
            st_r <= F_AA;
          end
        end
        F_AA:  st_r <= F_DD;
        F_DD:  st_r <= F_BB;
        F_BB:  st_r <= F_DB;
        F_DB:  st_r <= F_CHK;
        F_CHK: begin
          if (den_r <= 0 || mag_ge) begin
            st_r <= F_PUSH;
          end else begin
            st_r <= F_DIV;
          end
        end
        F_DIV: begin
          if (cnt_r == 5'd29) begin
            st_r <= F_SQ;
          end
        end
        F_SQ: st_r <= F_ROOT;
        F_ROOT: begin
          if (cnt_r == 5'd30) begin
            st_r <= F_CINIT;
          end
        end
        F_CINIT: st_r <= F_CORD;
        F_CORD: begin
          if (cnt_r == 5'(rbbq_pkg::CORDIC_STEPS - 1)) begin
            st_r <= F_FIN;
          end
        end
        F_FIN: st_r <= F_PUSH;
        F_PUSH: begin
          if (!q_full) begin
            st_r <= F_IDLE;
          end
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: begin
        a_r  <= $signed({{12{terrain_height[14]}}, terrain_height})
              + $signed({2'b0, earth_radius_eff});
        b_r  <= $signed({{12{radar_height[14]}}, radar_height})
              + $signed({2'b0, earth_radius_eff});
        d_r  <= ground_range;
        rs_r <= ray_start;
      end
      F_AA: num_r <= prod;
      F_DD: num_r <= num_r - prod;
      F_BB: num_r <= num_r - prod;
      F_DB: den_r <= prod <<< 1;
      F_CHK: begin
        neg_r <= num_r[55];
        if (den_r <= 0) begin
          phi_r <= num_r[55] ? -FULL_ANG : FULL_ANG;
        end else if (mag_ge) begin
          phi_r <= num_r[55] ? -FULL_ANG : FULL_ANG;
        end
        rem_r <= num_abs[47:0];
        s_r   <= '0;
        cnt_r <= '0;
      end
      F_DIV: begin
        rem_r <= div_ge ? rem_sub[47:0] : rem_sh[47:0];
        s_r   <= {s_r[28:0], div_ge};
        cnt_r <= cnt_r + 5'd1;
      end
      F_SQ: begin
        n_r   <= {1'b1, 60'b0} - {1'b0, sq};
        r_r   <= '0;
        cnt_r <= '0;
      end
      F_ROOT: begin
        if (root_ge) begin
          n_r <= n_r - trial;
          r_r <= (r_r >> 1) + rb;
        end else begin
          r_r <= r_r >> 1;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      F_CINIT: begin
        x_r   <= $signed({3'b0, r_r[30:0]});
        y_r   <= $signed({4'b0, s_r});
        z_r   <= '0;
        cnt_r <= '0;
      end
      F_CORD: begin
        if (!y_r[33]) begin
          x_r <= x_r + ysh;
          y_r <= y_r - xsh;
          z_r <= z_r + atan_s;
        end else begin
          x_r <= x_r - ysh;
          y_r <= y_r + xsh;
          z_r <= z_r - atan_s;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      F_FIN: phi_r <= neg_r ? -phi_mag : phi_mag;
      default: begin
      end
    endcase
  end

endmodule

### sv/rbbq_erf.sv
// Iterative erf unit: Horner polynomial, reciprocal by restoring division, four squarings.
module rbbq_erf (
  input  logic               clk,
  input  logic               rst_n,
  input  rbbq_pkg::erf_req_t req,
  output rbbq_pkg::erf_rsp_t rsp
);

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_HORN = 3'd1;
  localparam logic [2:0] E_DINI = 3'd2;
  localparam logic [2:0] E_DIV  = 3'd3;
  localparam logic [2:0] E_SQR  = 3'd4;
  localparam logic [2:0] E_DONE = 3'd5;

  logic [2:0]                     st_r;
  logic [2:0]                     step_r;
  logic [4:0]                     cnt_r;
  logic [rbbq_pkg::ERF_X_W-1:0]   x_r;
  logic [35:0]                    p_r, rem_r;
  logic [30:0]                    q_r;
  logic [rbbq_pkg::ERF_Y_W-1:0]   y_r;

  logic [54:0] hprod;
  logic [35:0] hterm;
  logic [36:0] rem_sh;
  logic        div_ge;
  logic [61:0] qsq;

  assign hprod  = p_r * x_r;
  assign hterm  = (step_r == 3'd5) ? 36'(rbbq_pkg::ONE_Q30)
                                   : 36'(rbbq_pkg::erf_coef(3'd4 - step_r));
  assign rem_sh = {rem_r, 1'b0};
  assign div_ge = rem_sh >= {1'b0, p_r};
  assign qsq    = q_r * q_r;

  assign rsp.done = (st_r == E_DONE);
  assign rsp.y    = y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      unique case (st_r)
        E_IDLE: begin
          if (req.start) begin
            st_r <= (req.x >= rbbq_pkg::ERF_SAT) ? E_DONE : E_HORN;
          end
        end
        E_HORN: begin
          if (step_r == 3'd5) begin
            st_r <= E_DINI;
          end
        end
        E_DINI: st_r <= E_DIV;
        E_DIV: begin
          if (cnt_r == 5'd30) begin
            st_r <= E_SQR;
          end
        end
        E_SQR: begin
          if (cnt_r == 5'd3) begin
            st_r <= E_DONE;
          end
        end
        E_DONE: st_r <= E_IDLE;
        default: st_r <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      E_IDLE: begin
        x_r    <= req.x;
        p_r    <= 36'(rbbq_pkg::erf_coef(3'd5));
        step_r <= '0;
        y_r    <= rbbq_pkg::ONE_Q30;
      end
      E_HORN: begin
        p_r    <= hterm + 36'(hprod >> 16);
        step_r <= step_r + 3'd1;
      end
      E_DINI: begin
        // 2^60 / p: the quotient fits 31 bits since p is at least 2^30.
        rem_r <= 36'(1 << 29);
        q_r   <= '0;
        cnt_r <= '0;
      end
      E_DIV: begin
        rem_r <= div_ge ? 36'(rem_sh - {1'b0, p_r}) : rem_sh[35:0];
        q_r   <= {q_r[29:0], div_ge};
        cnt_r <= (cnt_r == 5'd30) ? 5'd0 : cnt_r + 5'd1;
      end
      E_SQR: begin
        q_r   <= qsq[60:30];
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd3) begin
          y_r <= rbbq_pkg::ONE_Q30 - qsq[60:30];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/rbbq_back.sv
// Back part: running maximum, beam window, erf difference and the output register.
module rbbq_back #(
  parameter int AFB = 10,
  parameter int AW  = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [AW:0]        q_data,
  output logic               q_pop,
  input  logic signed [17:0] elevation_angle,
  input  logic [16:0]        elevation_limit,
  input  logic [24:0]        gauss_inv_width,
  input  logic [24:0]        erf_norm_inv,
  output rbbq_pkg::erf_req_t erf_req,
  input  rbbq_pkg::erf_rsp_t erf_rsp,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         quality,
  output logic               ray_start_echo
);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_WIN  = 4'd1;
  localparam logic [3:0] B_XU   = 4'd2;
  localparam logic [3:0] B_XL   = 4'd3;
  localparam logic [3:0] B_EUS  = 4'd4;
  localparam logic [3:0] B_EUW  = 4'd5;
  localparam logic [3:0] B_ELS  = 4'd6;
  localparam logic [3:0] B_ELW  = 4'd7;
  localparam logic [3:0] B_DIFF = 4'd8;
  localparam logic [3:0] B_QUAL = 4'd9;
  localparam logic [3:0] B_OUT  = 4'd10;

  localparam logic signed [AW-1:0] MAX_RST = -AW'(1 << (AFB + 7));
  localparam int YW = rbbq_pkg::ERF_Y_W;

  logic [3:0]                   st_r;
  logic signed [AW-1:0]         max_r;
  logic                         rs_r;
  logic                         du_neg_r;
  logic [16:0]                  mu_r;
  logic [rbbq_pkg::ERF_X_W-1:0] xu_r, xl_r;
  logic [YW-1:0]                eu_r, el_r;
  logic [YW-1:0]                bb_r;
  logic [7:0]                   qual_r;
  logic                         out_vld_r;
  logic [7:0]                   out_q_r;
  logic                         out_rs_r;

  logic signed [AW-1:0]         phi_in;
  logic signed [AW-1:0]         el_s, lim_s, lo, hi, eb, du;
  logic [16:0]                  mul_a;
  logic [41:0]                  xprod, xsh;
  logic [rbbq_pkg::ERF_X_W-1:0] xsat;
  logic signed [32:0]           eu_s, diff;
  logic [56:0]                  bprod;
  logic [39:0]                  bsh;
  logic [YW-1:0]                t;
  logic [38:0]                  q39;
  logic                         out_load;

  assign phi_in = $signed(q_data[AW-1:0]);
  assign el_s   = AW'(elevation_angle);
  assign lim_s  = $signed({{(AW - 17){1'b0}}, elevation_limit});
  assign lo     = el_s - lim_s;
  assign hi     = el_s + lim_s;
  assign eb     = (max_r > hi) ? hi : max_r;
  assign du     = el_s - eb;

  assign mul_a = (st_r == B_XU) ? mu_r : elevation_limit;
  assign xprod = mul_a * gauss_inv_width;
  assign xsh   = xprod >> AFB;
  assign xsat  = (xsh >= 42'(rbbq_pkg::ERF_SAT)) ? rbbq_pkg::ERF_SAT
                                                 : xsh[rbbq_pkg::ERF_X_W-1:0];

  assign eu_s  = du_neg_r ? -$signed({2'b0, eu_r}) : $signed({2'b0, eu_r});
  assign diff  = $signed({2'b0, el_r}) - eu_s;
  assign bprod = diff[31:0] * erf_norm_inv;
  assign bsh   = 40'(bprod >> 17);

  assign t   = rbbq_pkg::ONE_Q30 - bb_r;
  assign q39 = {t, 8'b0} - {8'b0, t};

  assign erf_req.start = (st_r == B_EUS) || (st_r == B_ELS);
  assign erf_req.x     = (st_r == B_ELS) ? xl_r : xu_r;

  assign q_pop    = (st_r == B_IDLE) && !q_empty;
  assign out_load = (st_r == B_OUT) && (!out_vld_r || pop);

  assign empty          = !out_vld_r;
  assign quality        = out_q_r;
  assign ray_start_echo = out_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= B_IDLE;
      max_r     <= MAX_RST;
      out_vld_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
      unique case (st_r)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_data[AW] || phi_in > max_r) begin
              max_r <= phi_in;
            end
            st_r <= B_WIN;
          end
        end
        B_WIN:  st_r <= (max_r < lo) ? B_OUT : B_XU;
        B_XU:   st_r <= B_XL;
        B_XL:   st_r <= B_EUS;
        B_EUS:  st_r <= B_EUW;
        B_EUW: begin
          if (erf_rsp.done) begin
            st_r <= B_ELS;
          end
        end
        B_ELS:  st_r <= B_ELW;
        B_ELW: begin
          if (erf_rsp.done) begin
            st_r <= B_DIFF;
          end
        end
        B_DIFF: st_r <= B_QUAL;
        B_QUAL: st_r <= B_OUT;
        B_OUT: begin
          if (out_load) begin
            st_r <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: rs_r <= q_data[AW];
      B_WIN: begin
        qual_r   <= 8'hFF;
        du_neg_r <= du < 0;
        mu_r     <= du < 0 ? 17'(-du) : 17'(du);
      end
      B_XU: xu_r <= xsat;
      B_XL: xl_r <= xsat;
      B_EUW: begin
        if (erf_rsp.done) begin
          eu_r <= erf_rsp.y;
        end
      end
      B_ELW: begin
        if (erf_rsp.done) begin
          el_r <= erf_rsp.y;
        end
      end
      B_DIFF: begin
        if (diff <= 0) begin
          bb_r <= '0;
        end else if (bsh > 40'(rbbq_pkg::ONE_Q30)) begin
          bb_r <= rbbq_pkg::ONE_Q30;
        end else begin
          bb_r <= bsh[YW-1:0];
        end
      end
      B_QUAL: qual_r <= q39[37:30];
      default: begin
      end
    endcase
    if (out_load) begin
      out_q_r  <= qual_r;
      out_rs_r <= rs_r;
    end
  end

endmodule

### sv/radar_beam_blockage_quality.sv
// Beam blockage quality top level: configuration registers, front, queue, back and erf unit.
//
// Each pushed range bin yields one 8-bit quality, in order. The front works out the terrain
// elevation angle with a 30-step divider, a 31-step square root and 24 CORDIC steps, unless
// it clamps the angle to plus or minus 90 degrees; the back then evaluates erf twice on one
// shared unit, unless the running maximum lies below the beam window, each evaluation a
// six-step polynomial, a 31-step reciprocal divider and four squarings, all skipped when
// the erf argument saturates. A queue of QUEUE_DEPTH angles lets the front start the next
// bin while the back is busy, and an output register holds a result until popped. The
// running maximum restarts on a bin with ray_start set.
module radar_beam_blockage_quality #(
  parameter int ANGLE_FRAC_BITS = 10,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [14:0]                   in_terrain_height,
  input  logic [19:0]                          in_ground_range,
  input  logic                                 in_ray_start,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [7:0]                           out_quality,
  output logic                                 out_ray_start_echo,
  input  logic                                 valid,
  output logic                                 ready,
  input  logic [rbbq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rbbq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = ((ANGLE_FRAC_BITS + 8 > 18) ? ANGLE_FRAC_BITS + 8 : 18) + 2;

  logic [24:0]        earth_radius_r;
  logic signed [14:0] radar_height_r;
  logic signed [17:0] elev_angle_r;
  logic [16:0]        elev_limit_r;
  logic [24:0]        gauss_iw_r;
  logic [24:0]        erf_norm_r;

  logic               f_push, f_full, b_pop, b_empty;
  logic [AW:0]        f_data, b_data;
  rbbq_pkg::erf_req_t erf_req;
  rbbq_pkg::erf_rsp_t erf_rsp;

  assign ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      earth_radius_r <= 25'd8495000;
      radar_height_r <= '0;
      elev_angle_r   <= 18'sd512;
      elev_limit_r   <= 17'd723;
      gauss_iw_r     <= 25'd109118;
      erf_norm_r     <= 25'd72490;
    end else if (valid && ready) begin
      unique case (cfg_index)
        rbbq_pkg::REG_EARTH_RADIUS: earth_radius_r <= cfg_data;
        rbbq_pkg::REG_RADAR_HEIGHT: radar_height_r <= $signed(cfg_data[14:0]);
        rbbq_pkg::REG_ELEV_ANGLE:   elev_angle_r   <= $signed(cfg_data[17:0]);
        rbbq_pkg::REG_ELEV_LIMIT:   elev_limit_r   <= cfg_data[16:0];
        rbbq_pkg::REG_GAUSS_IWIDTH: gauss_iw_r     <= cfg_data;
        rbbq_pkg::REG_ERF_NORM_INV: erf_norm_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rbbq_front #(
    .AFB (ANGLE_FRAC_BITS),
    .AW  (AW)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .terrain_height   (in_terrain_height),
    .ground_range     (in_ground_range),
    .ray_start        (in_ray_start),
    .full             (full),
    .earth_radius_eff (earth_radius_r),
    .radar_height     (radar_height_r),
    .q_push           (f_push),
    .q_data           (f_data),
    .q_full           (f_full)
  );

  rbbq_fifo #(
    .W     (AW + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_data),
    .full  (f_full),
    .pop   (b_pop),
    .dout  (b_data),
    .empty (b_empty)
  );

  rbbq_erf u_erf (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (erf_req),
    .rsp   (erf_rsp)
  );

  rbbq_back #(
    .AFB (ANGLE_FRAC_BITS),
    .AW  (AW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (b_empty),
    .q_data          (b_data),
    .q_pop           (b_pop),
    .elevation_angle (elev_angle_r),
    .elevation_limit (elev_limit_r),
    .gauss_inv_width (gauss_iw_r),
    .erf_norm_inv    (erf_norm_r),
    .erf_req         (erf_req),
    .erf_rsp         (erf_rsp),
    .empty           (empty),
    .pop             (pop),
    .quality         (out_quality),
    .ray_start_echo  (out_ray_start_echo)
  );

endmodule
